### design/bcpe_pkg.sv
package bcpe_pkg;

    localparam int PinW     = 12;
    localparam int BatW     = 14;
    localparam int PctW     = 7;
    localparam int DiffW    = 8;
    localparam int SegMulW  = 15;
    localparam int SegProdW = DiffW + SegMulW;
    localparam int SegShift = 17;

    localparam logic [BatW-1:0] ResetThreshMv = 14'd2500;

    // Divide by 100 as a multiply by 1311 / 2^17 (exact for products below 4699)
    localparam int Recip100 = 1311;

    // Curve breakpoints in battery millivolts
    localparam logic [BatW-1:0] FullMv  = 14'd4080;
    localparam logic [BatW-1:0] Seg1Mv  = 14'd3980;
    localparam logic [BatW-1:0] Seg2Mv  = 14'd3880;
    localparam logic [BatW-1:0] Seg3Mv  = 14'd3780;
    localparam logic [BatW-1:0] Seg4Mv  = 14'd3680;
    localparam logic [BatW-1:0] Seg5Mv  = 14'd3580;
    localparam logic [BatW-1:0] EmptyMv = 14'd3380;

    localparam logic [PctW-1:0] FullPct = 7'd100;

    // Slope per segment folded with the divide-by-100 reciprocal
    localparam logic [SegMulW-1:0] MulSlope20 = SegMulW'(20 * Recip100);
    localparam logic [SegMulW-1:0] MulSlope15 = SegMulW'(15 * Recip100);
    localparam logic [SegMulW-1:0] MulSlope13 = SegMulW'(13 * Recip100);
    // 12/200 of the lowest segment is 6/100
    localparam logic [SegMulW-1:0] MulSlope6  = SegMulW'(6 * Recip100);

    // EMA divide by 10 as multiply by 205 / 2^11 (exact below 1029)
    localparam int EmaSumW   = 10;
    localparam int Recip10W  = 8;
    localparam logic [Recip10W-1:0] Recip10 = 8'd205;
    localparam int EmaShift  = 11;
    localparam int EmaProdW  = EmaSumW + Recip10W;

    typedef struct packed {
        logic [BatW-1:0]    base_mv;
        logic [PctW-1:0]    offset_pct;
        logic [SegMulW-1:0] slope_mul;
    } seg_t;

endpackage

### design/battery_charge_percent_estimator.sv
// Pipeline: m_tvalid rises after an accepted input transaction passes the
// input register, curve register and result register.
// Throughput: one transaction per cycle while m_tready is high; the EMA update
// is computed into the result register, so back-to-back items never wait.
// Reset (aresetn low, synchronous): pipeline emptied, average unseeded and
// zeroed, absence threshold back to 2500 mV.
module battery_charge_percent_estimator
    import bcpe_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,

    input  logic            cfg_we,
    input  logic [BatW-1:0] cfg_wdata,   // absent_threshold_mv

    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,     // [11:0] pin_millivolts, [15:12] zero
    input  logic            s_tuser,     // [0] read_ok

    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,     // [6:0] charge_percent, [7] zero
    output logic            m_tuser      // [0] battery_present
);

    logic [BatW-1:0] thresh_reg;

    logic            in_valid_reg;
    logic [PinW-1:0] pin_reg;
    logic            ok_reg;

    logic            mid_valid_reg;
    logic [PctW-1:0] pct_reg;
    logic            present_reg;

    logic            out_valid_reg;
    logic [PctW-1:0] out_pct_reg;
    logic            out_present_reg;
    logic [PctW-1:0] smoothed_reg;
    logic [PctW-1:0] smoothed_next;
    logic            seeded_reg;

    logic            out_adv;
    logic            mid_adv;
    logic            in_adv;

    logic [BatW-1:0]     bat_mv;
    logic [PctW-1:0]     curve_pct;
    logic                present;
    logic [EmaSumW-1:0]  ema_sum;
    logic [EmaProdW-1:0] ema_prod;

    // Advance each stage when the one after it is empty or moving
    assign out_adv  = !out_valid_reg || m_tready;
    assign mid_adv  = !mid_valid_reg || out_adv;
    assign in_adv   = !in_valid_reg || mid_adv;
    assign s_tready = in_adv;

    // Hold the threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= ResetThreshMv;
        end else if (cfg_we) begin
            thresh_reg <= cfg_wdata;
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_tvalid) begin
            pin_reg <= s_tdata[PinW-1:0];
            ok_reg  <= s_tuser;
        end
    end

    // Undo the 3:1 divider and evaluate the curve
    assign bat_mv  = {1'b0, pin_reg, 1'b0} + {2'b00, pin_reg};
    assign present = ok_reg && (bat_mv >= thresh_reg);

    bcpe_curve u_curve (
        .bat_mv  (bat_mv),
        .percent (curve_pct)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (mid_adv) begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv && in_valid_reg) begin
            pct_reg     <= curve_pct;
            present_reg <= present;
        end
    end

    // EMA: floor((4*new + 6*old) / 10), seeded by the first valid percent
    assign ema_sum  = {1'b0, pct_reg, 2'b00}
                    + {1'b0, smoothed_reg, 2'b00}
                    + {2'b00, smoothed_reg, 1'b0};
    assign ema_prod = EmaProdW'(ema_sum) * EmaProdW'(Recip10);
    assign smoothed_next = seeded_reg ? ema_prod[EmaShift +: PctW] : pct_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            smoothed_reg  <= '0;
            seeded_reg    <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= mid_valid_reg;
            if (mid_valid_reg && present_reg) begin
                smoothed_reg <= smoothed_next;
                seeded_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && mid_valid_reg) begin
            out_pct_reg     <= present_reg ? smoothed_next : '0;
            out_present_reg <= present_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_pct_reg};
    assign m_tuser  = out_present_reg;

endmodule

### design/bcpe_curve.sv
module bcpe_curve
    import bcpe_pkg::*;
(
    input  logic [BatW-1:0] bat_mv,
    output logic [PctW-1:0] percent
);

    seg_t                seg;
    logic                full;
    logic                empty;
    logic [BatW-1:0]     diff;
    logic [SegProdW-1:0] prod;

    // Pick the segment that holds the voltage
    always_comb begin
        full  = 1'b0;
        empty = 1'b0;
        seg   = '{base_mv: EmptyMv, offset_pct: 7'd0, slope_mul: MulSlope6};
        priority if (bat_mv >= FullMv) begin
            full = 1'b1;
        end else if (bat_mv >= Seg1Mv) begin
            seg = '{base_mv: Seg1Mv, offset_pct: 7'd80, slope_mul: MulSlope20};
        end else if (bat_mv >= Seg2Mv) begin
            seg = '{base_mv: Seg2Mv, offset_pct: 7'd60, slope_mul: MulSlope20};
        end else if (bat_mv >= Seg3Mv) begin
            seg = '{base_mv: Seg3Mv, offset_pct: 7'd40, slope_mul: MulSlope20};
        end else if (bat_mv >= Seg4Mv) begin
            seg = '{base_mv: Seg4Mv, offset_pct: 7'd25, slope_mul: MulSlope15};
        end else if (bat_mv >= Seg5Mv) begin
            seg = '{base_mv: Seg5Mv, offset_pct: 7'd12, slope_mul: MulSlope13};
        end else if (bat_mv >= EmptyMv) begin
            seg = '{base_mv: EmptyMv, offset_pct: 7'd0, slope_mul: MulSlope6};
        end else begin
            empty = 1'b1;
        end
    end

    // Interpolate within the segment; offset below 200 mV fits DiffW bits
    assign diff = bat_mv - seg.base_mv;
    assign prod = SegProdW'(diff[DiffW-1:0]) * SegProdW'(seg.slope_mul);

    always_comb begin
        if (full) begin
            percent = FullPct;
        end else if (empty) begin
            percent = '0;
        end else begin
            percent = seg.offset_pct + prod[SegShift +: PctW];
        end
    end

endmodule

### sim/bcpe_soc_checker.sv
`timescale 1ns / 100ps

module bcpe_soc_checker
    import bcpe_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,

    input  logic            cfg_we,
    input  logic [BatW-1:0] cfg_wdata,   // absent_threshold_mv

    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [15:0]     s_tdata,     // [11:0] pin_millivolts, [15:12] zero
    input  logic            s_tuser,     // [0] read_ok

    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [7:0]      m_tdata,     // [6:0] charge_percent, [7] zero
    input  logic            m_tuser,     // [0] battery_present

    output int              mismatch_count,
    output int              results_due
);

    typedef struct packed {
        logic [PctW-1:0] charge_pct;
        logic            present;
    } soc_result_t;

    // Expected results in transaction order
    soc_result_t     charge_due[$];

    // Shadow copy of the block's register and smoothing state
    logic [BatW-1:0] thresh_mv;
    logic [PctW-1:0] avg_pct;
    logic            avg_seeded;

    initial begin
        mismatch_count = 0;
        results_due    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t bcpe_soc_checker: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Convert one reading to the expected result and advance the average
    function automatic soc_result_t predict_charge(input logic [PinW-1:0] pin_mv,
                                                   input logic            read_ok);
        int unsigned bat_mv;
        int unsigned pct;
        soc_result_t res;
        bat_mv = int'(pin_mv) * 3;
        res    = '0;
        if (!read_ok || bat_mv < int'(thresh_mv)) begin
            return res;
        end
        // Li-Ion discharge curve, every quotient truncated
        if (bat_mv >= 4080)      pct = 100;
        else if (bat_mv >= 3980) pct = 80 + (bat_mv - 3980) * 20 / 100;
        else if (bat_mv >= 3880) pct = 60 + (bat_mv - 3880) * 20 / 100;
        else if (bat_mv >= 3780) pct = 40 + (bat_mv - 3780) * 20 / 100;
        else if (bat_mv >= 3680) pct = 25 + (bat_mv - 3680) * 15 / 100;
        else if (bat_mv >= 3580) pct = 12 + (bat_mv - 3580) * 13 / 100;
        else if (bat_mv >= 3380) pct = (bat_mv - 3380) * 12 / 200;
        else                     pct = 0;
        // Seed the average with the first valid percent, then weight 4:6
        if (!avg_seeded) begin
            avg_pct    = PctW'(pct);
            avg_seeded = 1'b1;
        end else begin
            avg_pct = PctW'((4 * pct + 6 * int'(avg_pct)) / 10);
        end
        res.charge_pct = avg_pct;
        res.present    = 1'b1;
        return res;
    endfunction

    always @(posedge aclk) begin
        soc_result_t got;
        soc_result_t want;
        if (!aresetn) begin
            thresh_mv  = ResetThreshMv;
            avg_pct    = '0;
            avg_seeded = 1'b0;
            charge_due.delete();
        end else begin
            // Compare each result transaction with the oldest expectation
            if (m_tvalid && m_tready) begin
                got.charge_pct = m_tdata[PctW-1:0];
                got.present    = m_tuser;
                if (charge_due.size() == 0) begin
                    report_mismatch($sformatf("result (%0d, present %0b) with none expected",
                                              got.charge_pct, got.present));
                end else begin
                    want = charge_due.pop_front();
                    if (got.charge_pct !== want.charge_pct)
                        report_mismatch($sformatf("charge_percent %0d, expected %0d",
                                                  got.charge_pct, want.charge_pct));
                    if (got.present !== want.present)
                        report_mismatch($sformatf("battery_present %0b, expected %0b",
                                                  got.present, want.present));
                end
            end
            if (cfg_we) begin
                thresh_mv = cfg_wdata;
            end
            // Predict every accepted reading
            if (s_tvalid && s_tready) begin
                charge_due.push_back(predict_charge(s_tdata[PinW-1:0], s_tuser));
            end
        end
        results_due <= charge_due.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import bcpe_pkg::*;

    logic            aclk;
    logic            aresetn;
    logic            cfg_we;
    logic [BatW-1:0] cfg_wdata;
    logic            s_tvalid;
    logic            s_tready;
    logic [15:0]     s_tdata;
    logic            s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [7:0]      m_tdata;
    logic            m_tuser;

    int mismatch_count;
    int results_due;

    // Idle and stall chances in percent, and long hold-off requests
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;

    battery_charge_percent_estimator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    bcpe_soc_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the handshakes hang
    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off counted here on request
    initial begin
        int hold_ack;
        hold_ack = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one reading, with a random idle gap first, and hold until accepted
    task automatic offer_reading(input logic [PinW-1:0] pin_mv, input logic read_ok);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16 - PinW){1'b0}}, pin_mv};
        s_tuser  <= read_ok;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
    endtask

    // Write the absence threshold once the pipeline is empty
    task automatic write_threshold(input logic [BatW-1:0] thr_mv);
        drain_results();
        repeat (6) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr_mv;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int              sel;
        int              near_pin;
        int              ph;
        int              n;
        logic [BatW-1:0] thr_mv;
        logic [PinW-1:0] pin_mv;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: seed at full charge, failed reads, absence edge, every breakpoint
        offer_reading(12'd1360, 1'b1);
        offer_reading(12'd4095, 1'b1);
        offer_reading(12'd4095, 1'b0);
        offer_reading(12'd0,    1'b1);
        offer_reading(12'd0,    1'b0);
        offer_reading(12'd833,  1'b1);
        offer_reading(12'd834,  1'b1);
        offer_reading(12'd1359, 1'b1);
        offer_reading(12'd1327, 1'b1);
        offer_reading(12'd1326, 1'b1);
        offer_reading(12'd1294, 1'b1);
        offer_reading(12'd1293, 1'b1);
        offer_reading(12'd1260, 1'b1);
        offer_reading(12'd1259, 1'b1);
        offer_reading(12'd1227, 1'b1);
        offer_reading(12'd1226, 1'b1);
        offer_reading(12'd1194, 1'b1);
        offer_reading(12'd1193, 1'b1);
        offer_reading(12'd1127, 1'b1);
        offer_reading(12'd1126, 1'b1);
        offer_reading(12'd1126, 1'b0);
        offer_reading(12'd2730, 1'b1);
        offer_reading(12'd1365, 1'b1);

        // Random phases, each with a new threshold and one of four idle and stall patterns
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       thr_mv = '0;
                1:       thr_mv = 14'd16383;
                2:       thr_mv = 14'd12285;
                3:       thr_mv = 14'd2500;
                4:       thr_mv = BatW'($urandom_range(16383, 0));
                5:       thr_mv = BatW'($urandom_range(4200, 3300));
                6:       thr_mv = 14'd12286;
                default: thr_mv = BatW'($urandom_range(3000, 0));
            endcase
            write_threshold(thr_mv);
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 67;
                end
                default: begin
                    send_idle_pct  = 38;
                    recv_stall_pct <= 38;
                end
            endcase

            // Range extremes against the new threshold
            offer_reading(12'd4095, 1'b1);
            offer_reading(12'd0,    1'b1);

            for (n = 0; n < 203; n++) begin
                // Hold the receiver off while the sender keeps pushing
                if (ph == 0 && n == 40) begin
                    hold_req <= hold_req + 1;
                end
                if (n == 100) begin
                    drain_results();
                end
                sel = $urandom_range(99);
                if (sel < 70) begin
                    pin_mv = PinW'($urandom_range(1410, 1100));
                end else if (sel < 85) begin
                    pin_mv = PinW'($urandom_range(4095, 0));
                end else begin
                    // Land close to the absence threshold
                    near_pin = int'(thr_mv) / 3 + int'($urandom_range(4)) - 2;
                    if (near_pin < 0)    near_pin = 0;
                    if (near_pin > 4095) near_pin = 4095;
                    pin_mv = PinW'(near_pin);
                end
                offer_reading(pin_mv, ($urandom_range(9) != 0));
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
